>>> rtl/pnct_pkg.sv
// ----------------------------------------------------------------------------
// pnct_pkg
// Shared types and constants of the nearest palette color temperature core.
// ----------------------------------------------------------------------------
package pnct_pkg;

    localparam int PALETTE_DEPTH_DEF = 512;
    localparam int BIN_COUNT_DEF     = 32;

    localparam int TEMP_W   = 21;
    localparam int CNT_W    = 10;
    localparam int COLOR_W  = 8;
    localparam int EIDX_W   = 9;
    localparam int MIDX_W   = 9;
    localparam int ENTRY_W  = 3 * COLOR_W;
    localparam int PROD_W   = TEMP_W + CNT_W;
    localparam int STEP_W   = $clog2(PROD_W);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOT_TEMP      = 2'd0,
        CFG_COLD_TEMP     = 2'd1,
        CFG_PALETTE_COUNT = 2'd2,
        CFG_QUANTIZE      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE
    } core_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_RUN,
        DV_DONE
    } div_state_t;

    typedef struct packed {
        logic               en;
        logic [EIDX_W-1:0]  index;
        logic [ENTRY_W-1:0] entry;
    } load_t;

    typedef struct packed {
        logic               start;
        logic               quant;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] l;
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] b;
    } search_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] best;
    } search_rsp_t;

    typedef struct packed {
        logic                     start;
        logic [CNT_W-1:0]         best;
        logic [CNT_W-1:0]         count;
        logic signed [TEMP_W-1:0] hot_temp;
        logic signed [TEMP_W-1:0] cold_temp;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TEMP_W-1:0] temperature;
    } div_rsp_t;

endpackage

>>> rtl/pnct_search.sv
// ----------------------------------------------------------------------------
// pnct_search
// Palette memory and nearest entry scan, one entry read per cycle through a
// pipeline of difference, square, sum and compare stages.
// ----------------------------------------------------------------------------
module pnct_search #(
    parameter int PALETTE_DEPTH = pnct_pkg::PALETTE_DEPTH_DEF,
    parameter int BIN_COUNT     = pnct_pkg::BIN_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pnct_pkg::load_t       load,
    input  pnct_pkg::search_req_t req,
    output pnct_pkg::search_rsp_t rsp
);
    import pnct_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int SCL_W  = BIN_W + 9;
    localparam int DIST_W = 2 * SCL_W + 2;
    localparam int BPROD_W = COLOR_W + 9;

    logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;
    logic [ADDR_W+EIDX_W-1:0] wr_ext;
    logic [ADDR_W+CNT_W-1:0]  rd_ext;

    logic             issue_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] last_reg;

    logic [SCL_W-1:0] pix_l_reg, pix_a_reg, pix_b_reg;
    logic [SCL_W-1:0] pix_l_next, pix_a_next, pix_b_next;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CNT_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    logic [SCL_W-1:0]   ent_l, ent_a, ent_b;
    logic [SCL_W-1:0]   dl_reg, da_reg, db_reg;
    logic [2*SCL_W-1:0] sl_reg, sa_reg, sb_reg;
    logic [DIST_W-1:0]  sum_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [CNT_W-1:0]   best_reg;
    logic               done_reg;

    function automatic logic [SCL_W-1:0] scale_pixel(input logic [COLOR_W-1:0] c,
                                                     input logic quant);
        logic [BPROD_W-1:0] bp;
        logic [BIN_W-1:0]   bin;
        bp  = BPROD_W'(c) * BPROD_W'(BIN_COUNT);
        bin = bp[BIN_W+7:8];
        if (quant) begin
            return {bin, 1'b1, 8'd0};
        end
        return SCL_W'(c) * SCL_W'(2 * BIN_COUNT);
    endfunction

    function automatic logic [SCL_W-1:0] absdiff(input logic [SCL_W-1:0] x,
                                                 input logic [SCL_W-1:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    assign wr_ext  = {{ADDR_W{1'b0}}, load.index};
    assign wr_addr = wr_ext[ADDR_W-1:0];
    assign wr_ok   = load.en && (32'(load.index) < PALETTE_DEPTH);
    assign rd_ext  = {{ADDR_W{1'b0}}, rd_cnt_reg};
    assign rd_addr = rd_ext[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= load.entry;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign pix_l_next = scale_pixel(req.l, req.quant);
    assign pix_a_next = scale_pixel(req.a, req.quant);
    assign pix_b_next = scale_pixel(req.b, req.quant);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= 1'b0;
            rd_cnt_reg <= '0;
        end else if (req.start) begin
            issue_reg  <= 1'b1;
            rd_cnt_reg <= '0;
        end else if (issue_reg) begin
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
            if (rd_cnt_reg == last_reg) begin
                issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            last_reg  <= req.count - 1'b1;
            pix_l_reg <= pix_l_next;
            pix_a_reg <= pix_a_next;
            pix_b_reg <= pix_b_next;
        end
    end

    assign ent_l = SCL_W'(rdata_reg[3*COLOR_W-1:2*COLOR_W]) * SCL_W'(2 * BIN_COUNT);
    assign ent_a = SCL_W'(rdata_reg[2*COLOR_W-1:COLOR_W]) * SCL_W'(2 * BIN_COUNT);
    assign ent_b = SCL_W'(rdata_reg[COLOR_W-1:0]) * SCL_W'(2 * BIN_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= issue_reg && !req.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg && (idx4_reg == last_reg);
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= rd_cnt_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        dl_reg   <= absdiff(pix_l_reg, ent_l);
        da_reg   <= absdiff(pix_a_reg, ent_a);
        db_reg   <= absdiff(pix_b_reg, ent_b);
        sl_reg   <= dl_reg * dl_reg;
        sa_reg   <= da_reg * da_reg;
        sb_reg   <= db_reg * db_reg;
        sum_reg  <= DIST_W'(sl_reg) + DIST_W'(sa_reg) + DIST_W'(sb_reg);
        if (v4_reg && ((idx4_reg == '0) || (sum_reg < best_d_reg))) begin
            best_d_reg <= sum_reg;
            best_reg   <= idx4_reg;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.best = best_reg;

endmodule

>>> rtl/pnct_divider.sv
// ----------------------------------------------------------------------------
// pnct_divider
// Temperature interpolation: index times span, then a restoring divide by
// count minus one, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnct_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  pnct_pkg::div_req_t req,
    output pnct_pkg::div_rsp_t rsp
);
    import pnct_pkg::*;

    div_state_t state_reg, state_next;

    logic [CNT_W-1:0]  best_reg;
    logic [TEMP_W-1:0] mag_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;
    logic [TEMP_W-1:0] max_reg;
    logic [PROD_W-1:0] num_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;

    logic [TEMP_W:0]   span;
    logic [TEMP_W:0]   span_mag;
    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [CNT_W-1:0]  rem_next;
    logic [TEMP_W-1:0] q_low;

    assign span     = {req.hot_temp[TEMP_W-1], req.hot_temp}
                    - {req.cold_temp[TEMP_W-1], req.cold_temp};
    assign span_mag = span[TEMP_W] ? (TEMP_W+1)'(0) - span : span;

    assign rem_sh   = {rem_reg, num_reg[PROD_W-1]};
    assign q_bit    = rem_sh >= {1'b0, div_reg};
    assign rem_next = q_bit ? CNT_W'(rem_sh - {1'b0, div_reg}) : rem_sh[CNT_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE: begin
                if (req.start) state_next = DV_MUL;
            end
            DV_MUL: begin
                state_next = DV_RUN;
            end
            DV_RUN: begin
                if (step_reg == STEP_W'(PROD_W - 1)) state_next = DV_DONE;
            end
            DV_DONE: begin
                if (req.start) state_next = DV_MUL;
            end
            default: begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            best_reg <= req.best;
            mag_reg  <= span_mag[TEMP_W-1:0];
            div_reg  <= (req.count > CNT_W'(1)) ? req.count - 1'b1 : CNT_W'(1);
            neg_reg  <= span[TEMP_W];
            max_reg  <= req.hot_temp;
        end
        case (state_reg)
            DV_MUL: begin
                num_reg  <= PROD_W'(best_reg) * PROD_W'(mag_reg);
                rem_reg  <= '0;
                step_reg <= '0;
            end
            DV_RUN: begin
                num_reg  <= {num_reg[PROD_W-2:0], q_bit};
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign q_low = num_reg[TEMP_W-1:0];

    always_comb begin
        rsp.done        = (state_reg == DV_DONE);
        rsp.temperature = neg_reg ? signed'(max_reg + q_low) : signed'(max_reg - q_low);
    end

endmodule

>>> rtl/palette_nearest_color_temperature_core.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_temperature_core
// Nearest palette color match with linear temperature interpolation.
// Load: written to palette memory on acceptance. Query: memory scan (one
// entry read per cycle), then multiply, divide and output register; the next
// item is taken only after the result has entered the output register.
// One query at a time; a stalled result holds off the input.
// Synchronous active low reset clears control and configuration; palette
// memory is not cleared.
// ----------------------------------------------------------------------------
module palette_nearest_color_temperature_core #(
    parameter int PALETTE_DEPTH = pnct_pkg::PALETTE_DEPTH_DEF,
    parameter int BIN_COUNT     = pnct_pkg::BIN_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  pnct_pkg::cfg_idx_t                cfg_index,
    input  logic [pnct_pkg::TEMP_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [pnct_pkg::EIDX_W-1:0]       s_entry_index,
    input  logic [pnct_pkg::COLOR_W-1:0]      s_color_l,
    input  logic [pnct_pkg::COLOR_W-1:0]      s_color_a,
    input  logic [pnct_pkg::COLOR_W-1:0]      s_color_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pnct_pkg::TEMP_W-1:0] m_temperature,
    output logic [pnct_pkg::MIDX_W-1:0]       m_match_index
);
    import pnct_pkg::*;

    core_state_t state_reg, state_next;

    logic signed [TEMP_W-1:0] hot_temp_reg;
    logic signed [TEMP_W-1:0] cold_temp_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     quant_reg;
    logic [CNT_W-1:0]         count_eff;

    logic accept;
    logic out_load;
    logic search_start;
    logic div_start;

    load_t       load;
    search_req_t sreq;
    search_rsp_t srsp;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] m_temperature_reg;
    logic [MIDX_W-1:0]        m_match_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hot_temp_reg  <= '0;
            cold_temp_reg <= '0;
            count_reg     <= CNT_W'(1);
            quant_reg     <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HOT_TEMP:      hot_temp_reg  <= signed'(cfg_wdata);
                CFG_COLD_TEMP:     cold_temp_reg <= signed'(cfg_wdata);
                CFG_PALETTE_COUNT: count_reg     <= cfg_wdata[CNT_W-1:0];
                CFG_QUANTIZE:      quant_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (count_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (32'(count_reg) > PALETTE_DEPTH) begin
            count_eff = CNT_W'(PALETTE_DEPTH);
        end else begin
            count_eff = count_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_req_type == REQ_QUERY)) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (srsp.done) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (drsp.done && (!m_valid_reg || m_ready)) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        search_start = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                search_start = s_valid && (s_req_type == REQ_QUERY);
            end
            ST_SEARCH: begin
                div_start = srsp.done;
            end
            ST_DIVIDE: begin
                out_load = drsp.done && (!m_valid_reg || m_ready);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_temperature_reg <= drsp.temperature;
            m_match_index_reg <= srsp.best[MIDX_W-1:0];
        end
    end

    assign accept = s_valid && s_ready;

    assign load.en    = accept && (s_req_type == REQ_LOAD);
    assign load.index = s_entry_index;
    assign load.entry = {s_color_l, s_color_a, s_color_b};

    assign sreq.start = search_start;
    assign sreq.quant = quant_reg;
    assign sreq.count = count_eff;
    assign sreq.l     = s_color_l;
    assign sreq.a     = s_color_a;
    assign sreq.b     = s_color_b;

    assign dreq.start     = div_start;
    assign dreq.best      = srsp.best;
    assign dreq.count     = count_eff;
    assign dreq.hot_temp  = hot_temp_reg;
    assign dreq.cold_temp = cold_temp_reg;

    pnct_search #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .BIN_COUNT     (BIN_COUNT)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .req     (sreq),
        .rsp     (srsp)
    );

    pnct_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign m_valid       = m_valid_reg;
    assign m_temperature = m_temperature_reg;
    assign m_match_index = m_match_index_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest palette color temperature core.
// Palette entries are loaded and Lab pixels are queried under a range of
// register settings and handshake idling patterns. Every result is checked
// against an in-bench model of the nearest-entry search and the linear
// temperature interpolation.
// ----------------------------------------------------------------------------
module tb_top;
    import pnct_pkg::*;

    localparam int PALETTE_DEPTH = PALETTE_DEPTH_DEF;
    localparam int BIN_COUNT     = BIN_COUNT_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int TEMP_LOW      = -20000;
    localparam int TEMP_HIGH     = 1000000;

    typedef struct packed {
        logic [COLOR_W-1:0] l;
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] b;
    } lab_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [MIDX_W-1:0] match_index;
    } match_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    cfg_idx_t                 cfg_index;
    logic [TEMP_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_req_type;
    logic [EIDX_W-1:0]        s_entry_index;
    logic [COLOR_W-1:0]       s_color_l;
    logic [COLOR_W-1:0]       s_color_a;
    logic [COLOR_W-1:0]       s_color_b;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [TEMP_W-1:0] m_temperature;
    logic [MIDX_W-1:0]        m_match_index;

    // shadow of the block's state
    lab_t                     palette_mem [PALETTE_DEPTH];
    logic signed [TEMP_W-1:0] hot_temp_q  = '0;
    logic signed [TEMP_W-1:0] cold_temp_q = '0;
    logic [CNT_W-1:0]         count_q     = 1;
    logic                     quant_q     = 1'b1;

    match_t expected_matches [$];
    int     mismatch_count = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles    = 0;
    longint cycle_count    = 0;

    palette_nearest_color_temperature_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_index (s_entry_index),
        .s_color_l     (s_color_l),
        .s_color_a     (s_color_a),
        .s_color_b     (s_color_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_temperature (m_temperature),
        .m_match_index (m_match_index)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic longint unsigned scaled_channel(input logic [COLOR_W-1:0] c,
                                                       input logic quant);
        longint unsigned cv;
        longint unsigned bin_idx;
        cv = c;
        if (quant) begin
            bin_idx = (cv * BIN_COUNT) >> 8;
            if (bin_idx > BIN_COUNT - 1)
                bin_idx = BIN_COUNT - 1;
            return (2 * bin_idx + 1) * 256;
        end
        return cv * 2 * BIN_COUNT;
    endfunction

    function automatic longint unsigned sq_diff(input longint unsigned x,
                                                input longint unsigned y);
        longint unsigned d;
        d = (x > y) ? x - y : y - x;
        return d * d;
    endfunction

    function automatic match_t nearest_match(input lab_t px);
        longint unsigned pl, pa, pb, el, ea, eb, distance, best_dist;
        longint          span, mag, quot, temp;
        int unsigned     n, best_idx, divisor;
        match_t          r;
        n = count_q;
        if (n < 1)
            n = 1;
        if (n > PALETTE_DEPTH)
            n = PALETTE_DEPTH;
        pl = scaled_channel(px.l, quant_q);
        pa = scaled_channel(px.a, quant_q);
        pb = scaled_channel(px.b, quant_q);
        best_idx  = 0;
        best_dist = 0;
        for (int unsigned i = 0; i < n; i++) begin
            el = palette_mem[i].l;
            ea = palette_mem[i].a;
            eb = palette_mem[i].b;
            el = el * 2 * BIN_COUNT;
            ea = ea * 2 * BIN_COUNT;
            eb = eb * 2 * BIN_COUNT;
            distance = sq_diff(pl, el) + sq_diff(pa, ea) + sq_diff(pb, eb);
            if (i == 0 || distance < best_dist) begin
                best_dist = distance;
                best_idx  = i;
            end
        end
        divisor = (n > 1) ? n - 1 : 1;
        span = longint'(hot_temp_q) - longint'(cold_temp_q);
        mag  = (span < 0) ? -span : span;
        quot = (longint'(best_idx) * mag) / longint'(divisor);
        temp = (span < 0) ? longint'(hot_temp_q) + quot : longint'(hot_temp_q) - quot;
        r.temperature = temp[TEMP_W-1:0];
        r.match_index = best_idx[MIDX_W-1:0];
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [COLOR_W-1:0] random_channel();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return COLOR_W'($urandom_range(255));
    endfunction

    function automatic lab_t random_color();
        lab_t c;
        c.l = random_channel();
        c.a = random_channel();
        c.b = random_channel();
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] jitter(input logic [COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COLOR_W'(v);
    endfunction

    // pixel close to a given palette entry, to stress near ties
    function automatic lab_t near_color(input lab_t e);
        lab_t c;
        c.l = jitter(e.l);
        c.a = jitter(e.a);
        c.b = jitter(e.b);
        return c;
    endfunction

    function automatic lab_t lab(input int l, input int a, input int b);
        lab_t c;
        c.l = COLOR_W'(l);
        c.a = COLOR_W'(a);
        c.b = COLOR_W'(b);
        return c;
    endfunction

    function automatic int random_temp();
        return int'($urandom_range(TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
    endfunction

    task automatic send_item(input req_type_t req, input logic [EIDX_W-1:0] idx,
                             input lab_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_entry_index <= idx;
        s_color_l     <= c.l;
        s_color_a     <= c.a;
        s_color_b     <= c.b;
        do @(posedge aclk); while (!s_ready);
        if (req == REQ_LOAD)
            palette_mem[idx] = c;
        else
            expected_matches = {expected_matches, nearest_match(c)};
    endtask

    // drain all results, then let any load still in the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [TEMP_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HOT_TEMP:      hot_temp_q  = value;
            CFG_COLD_TEMP:     cold_temp_q = value;
            CFG_PALETTE_COUNT: count_q     = value[CNT_W-1:0];
            CFG_QUANTIZE:      quant_q     = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int max_t, input int min_t, input int count,
                              input int quant);
        wait_idle();
        cfg_write(CFG_HOT_TEMP, TEMP_W'(max_t));
        cfg_write(CFG_COLD_TEMP, TEMP_W'(min_t));
        cfg_write(CFG_PALETTE_COUNT, TEMP_W'(count));
        cfg_write(CFG_QUANTIZE, TEMP_W'(quant));
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        // defaults after reset: single entry, quantizing on, temperatures zero
        send_item(REQ_LOAD, 0, lab(0, 0, 0));
        send_item(REQ_QUERY, 0, lab(255, 255, 255));

        // count of zero acts as one
        set_config(TEMP_HIGH, TEMP_LOW, 0, 0);
        send_item(REQ_QUERY, EIDX_W'(511), lab(0, 0, 0));

        send_item(REQ_LOAD, 1, lab(255, 255, 255));
        send_item(REQ_LOAD, 2, lab(128, 128, 128));
        send_item(REQ_LOAD, 3, lab(0, 0, 0));       // tie with entry 0
        send_item(REQ_LOAD, 4, lab(7, 250, 16));
        send_item(REQ_LOAD, EIDX_W'(511), lab(255, 0, 255));

        set_config(TEMP_HIGH, TEMP_LOW, 5, 0);
        send_item(REQ_QUERY, 0, lab(0, 0, 0));
        send_item(REQ_QUERY, 0, lab(255, 255, 255));
        send_item(REQ_QUERY, 0, lab(130, 126, 129));
        send_item(REQ_QUERY, 0, lab(7, 250, 16));
        send_item(REQ_QUERY, 0, lab(255, 0, 255));
        send_item(REQ_QUERY, 0, lab(64, 192, 32));

        // min above max, quantizing on
        set_config(TEMP_LOW, TEMP_HIGH, 5, 1);
        send_item(REQ_QUERY, 0, lab(0, 0, 0));
        send_item(REQ_QUERY, 0, lab(7, 250, 16));
        send_item(REQ_QUERY, 0, lab(3, 251, 20));
        send_item(REQ_QUERY, 0, lab(255, 255, 255));

        // equal temperatures
        set_config(TEMP_HIGH, TEMP_HIGH, 5, 1);
        send_item(REQ_QUERY, 0, lab(128, 128, 128));
    endtask

    task automatic test_full_palette();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            send_item(REQ_LOAD, EIDX_W'(i), random_color());

        set_config(TEMP_HIGH, TEMP_LOW, PALETTE_DEPTH, 0);
        send_item(REQ_QUERY, 0, palette_mem[511]);
        send_item(REQ_QUERY, 0, palette_mem[256]);
        send_item(REQ_QUERY, 0, palette_mem[300]);
        send_item(REQ_QUERY, 0, random_color());

        // count above the depth acts as the depth
        set_config(TEMP_LOW, TEMP_HIGH, 1023, 1);
        send_item(REQ_QUERY, 0, palette_mem[400]);
        send_item(REQ_QUERY, 0, random_color());
        send_item(REQ_QUERY, 0, random_color());

        set_config(random_temp(), random_temp(), PALETTE_DEPTH - 1, 0);
        send_item(REQ_QUERY, 0, palette_mem[510]);
        send_item(REQ_QUERY, 0, random_color());
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int rounds, input int items);
        int sel;
        int count;
        int n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (rounds) begin
            sel = $urandom_range(9);
            if (sel == 0)
                count = $urandom_range(1);
            else if (sel == 1)
                count = $urandom_range(100, 17);
            else
                count = $urandom_range(16, 2);
            n = (count < 1) ? 1 : count;
            set_config(random_temp(), random_temp(), count, $urandom_range(1));
            repeat (items) begin
                sel = $urandom_range(99);
                if (sel < 40) begin
                    if ($urandom_range(3) == 0)
                        send_item(REQ_LOAD, EIDX_W'($urandom_range(PALETTE_DEPTH - 1)),
                                  random_color());
                    else
                        send_item(REQ_LOAD, EIDX_W'($urandom_range(n - 1)),
                                  random_color());
                end else if (sel < 70) begin
                    send_item(REQ_QUERY, EIDX_W'($urandom_range(PALETTE_DEPTH - 1)),
                              near_color(palette_mem[$urandom_range(n - 1)]));
                end else begin
                    send_item(REQ_QUERY, EIDX_W'($urandom_range(PALETTE_DEPTH - 1)),
                              random_color());
                end
            end
        end
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        set_config(random_temp(), random_temp(), 8, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        repeat (12)
            send_item(REQ_QUERY, 0, near_color(palette_mem[$urandom_range(7)]));
    endtask

    // ---------------- result side ----------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        match_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected item: temperature %0d match_index %0d",
                             m_temperature, m_match_index);
                mismatch_count++;
            end else begin
                want = expected_matches.pop_front();
                if (m_temperature !== want.temperature ||
                    m_match_index !== want.match_index) begin
                    if (mismatch_count < 10)
                        $display("mismatch: temp exp %0d got %0d, index exp %0d got %0d",
                                 $signed(want.temperature), m_temperature,
                                 want.match_index, m_match_index);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** palette_nearest_color_temperature_core: FAILED **");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HOT_TEMP;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_req_type    = REQ_LOAD;
        s_entry_index = '0;
        s_color_l     = '0;
        s_color_a     = '0;
        s_color_b     = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_full_palette();
        test_random_traffic(0, 0, 5, 30);
        test_random_traffic(87, 0, 5, 30);
        test_random_traffic(0, 87, 5, 30);
        test_random_traffic(23, 23, 5, 30);
        test_output_backpressure();
        wait_idle();

        if (mismatch_count == 0 && expected_matches.size() == 0)
            $display("** palette_nearest_color_temperature_core: PASSED **");
        else
            $display("** palette_nearest_color_temperature_core: FAILED **");
        $finish;
    end

endmodule

>>> palette_nearest_color_temperature_core.f
rtl/pnct_pkg.sv
rtl/pnct_search.sv
rtl/pnct_divider.sv
rtl/palette_nearest_color_temperature_core.sv
tb/tb_top.sv
